// File: hw/rtl/scp_pkg.sv
package scp_pkg;

  localparam int unsigned TagBits     = 48;
  localparam int unsigned UsageBits   = 8;
  localparam int unsigned SlotOutBits = 3;
  localparam int unsigned DefSlots    = 8;
  localparam logic [UsageBits-1:0] UsageMax = 8'hFF;

  typedef enum logic [1:0] {
    OP_SELECT = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_RECORD = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_SELECTED  = 3'd0,
    KIND_CLEARED   = 3'd1,
    KIND_NOT_FOUND = 3'd2,
    KIND_WRITEBACK = 3'd3,
    KIND_DEV_FLUSH = 3'd4,
    KIND_RECORDED  = 3'd5
  } kind_e;

  // Write command from the sequencer to the slot store
  typedef struct packed {
    logic                 tag_en;
    logic                 dirty_en;
    logic                 usage_en;
    logic [TagBits-1:0]   tag;
    logic                 dirty;
    logic [UsageBits-1:0] usage;
  } wr_cmd_t;

endpackage

// File: hw/rtl/scp_store.sv
module scp_store #(
  parameter int unsigned SLOTS = scp_pkg::DefSlots
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [$clog2(SLOTS)-1:0]           rd_idx_i,
  output logic [scp_pkg::TagBits-1:0]        rd_tag_o,
  output logic                               rd_dirty_o,
  output logic [scp_pkg::UsageBits-1:0]      rd_usage_o,
  input  logic [$clog2(SLOTS)-1:0]           wr_idx_i,
  input  scp_pkg::wr_cmd_t                   wr_i
);

  logic [scp_pkg::TagBits-1:0]   tags_q  [SLOTS];
  logic [scp_pkg::UsageBits-1:0] usage_q [SLOTS];
  logic [SLOTS-1:0]              dirty_q;

  assign rd_tag_o   = tags_q[rd_idx_i];
  assign rd_dirty_o = dirty_q[rd_idx_i];
  assign rd_usage_o = usage_q[rd_idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        tags_q[i]  <= '0;
        usage_q[i] <= '0;
      end
      dirty_q <= '0;
    end else begin
      if (wr_i.tag_en) begin
        tags_q[wr_idx_i] <= wr_i.tag;
      end
      if (wr_i.usage_en) begin
        usage_q[wr_idx_i] <= wr_i.usage;
      end
      if (wr_i.dirty_en) begin
        dirty_q[wr_idx_i] <= wr_i.dirty;
      end
    end
  end

endmodule

// File: hw/rtl/scp_seq.sv
module scp_seq #(
  parameter int unsigned SLOTS = scp_pkg::DefSlots
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wb_en_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          opcode_i,
  input  logic [scp_pkg::TagBits-1:0]         block_number_i,
  input  logic [2:0]                          slot_index_i,
  input  logic                                dirty_in_i,
  input  logic [scp_pkg::UsageBits-1:0]       usage_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [2:0]                          kind_o,
  output logic [scp_pkg::SlotOutBits-1:0]     slot_out_o,
  output logic [scp_pkg::TagBits-1:0]         block_out_o,
  output logic                                last_o,
  output logic [$clog2(SLOTS)-1:0]            rd_idx_o,
  input  logic [scp_pkg::TagBits-1:0]         rd_tag_i,
  input  logic                                rd_dirty_i,
  input  logic [scp_pkg::UsageBits-1:0]       rd_usage_i,
  output logic [$clog2(SLOTS)-1:0]            wr_idx_o,
  output scp_pkg::wr_cmd_t                    wr_o
);

  localparam int unsigned SlotW = $clog2(SLOTS);
  localparam int unsigned CntW  = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WB,
    S_DONE
  } state_e;

  state_e                          state_q, state_d;
  scp_pkg::op_e                    op_q, op_d;
  logic [scp_pkg::TagBits-1:0]     blk_q, blk_d;
  logic [2:0]                      sidx_q, sidx_d;
  logic                            din_q, din_d;
  logic [scp_pkg::UsageBits-1:0]   uin_q, uin_d;
  logic [CntW-1:0]                 idx_q, idx_d;
  logic [SlotW-1:0]                clean_q, clean_d;
  logic                            have_clean_q, have_clean_d;
  logic [SlotW-1:0]                best_q, best_d;
  logic                            have_low_q, have_low_d;
  logic [scp_pkg::UsageBits-1:0]   lowest_q, lowest_d;
  logic [SlotW-1:0]                rr_q, rr_d;
  scp_pkg::kind_e                  res_kind_q, res_kind_d;
  logic [scp_pkg::SlotOutBits-1:0] res_slot_q, res_slot_d;

  logic                            out_valid_q, out_valid_d;
  scp_pkg::kind_e                  kind_q, kind_d;
  logic [scp_pkg::SlotOutBits-1:0] slot_q, slot_d;
  logic [scp_pkg::TagBits-1:0]     block_q, block_d;
  logic                            last_q, last_d;

  logic             out_free;
  logic             scan_end;
  logic             tag_hit;
  logic [SlotW-1:0] cur;

  assign out_free = !out_valid_q || out_ready_i;
  assign scan_end = (idx_q == CntW'(SLOTS));
  assign cur      = idx_q[SlotW-1:0];
  assign tag_hit  = (rd_tag_i == blk_q);
  assign rd_idx_o = cur;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign slot_out_o  = slot_q;
  assign block_out_o = block_q;
  assign last_o      = last_q;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    blk_d        = blk_q;
    sidx_d       = sidx_q;
    din_d        = din_q;
    uin_d        = uin_q;
    idx_d        = idx_q;
    clean_d      = clean_q;
    have_clean_d = have_clean_q;
    best_d       = best_q;
    have_low_d   = have_low_q;
    lowest_d     = lowest_q;
    rr_d         = rr_q;
    res_kind_d   = res_kind_q;
    res_slot_d   = res_slot_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    kind_d       = kind_q;
    slot_d       = slot_q;
    block_d      = block_q;
    last_d       = last_q;
    wr_o         = '0;
    wr_idx_o     = cur;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d         = scp_pkg::op_e'(opcode_i);
          blk_d        = block_number_i;
          sidx_d       = slot_index_i;
          din_d        = dirty_in_i;
          uin_d        = usage_in_i;
          idx_d        = '0;
          have_clean_d = 1'b0;
          have_low_d   = 1'b0;
          lowest_d     = scp_pkg::UsageMax;
          clean_d      = '0;
          best_d       = '0;
          state_d      = S_SCAN;
        end
      end

      S_SCAN: begin
        case (op_q)
          scp_pkg::OP_SELECT: begin
            res_kind_d = scp_pkg::KIND_SELECTED;
            if (scan_end) begin
              if (have_clean_q) begin
                res_slot_d = scp_pkg::SlotOutBits'(clean_q);
              end else if (have_low_q) begin
                res_slot_d = scp_pkg::SlotOutBits'(best_q);
              end else begin
                // fall back on the round-robin pointer and advance it
                res_slot_d = scp_pkg::SlotOutBits'(rr_q);
                rr_d = (rr_q == SlotW'(SLOTS - 1)) ? '0 : rr_q + 1'b1;
              end
              state_d = S_DONE;
            end else if (rd_dirty_i && tag_hit) begin
              res_slot_d = scp_pkg::SlotOutBits'(cur);
              state_d    = S_DONE;
            end else begin
              if (!rd_dirty_i) begin
                clean_d      = cur;
                have_clean_d = 1'b1;
              end
              if (rd_usage_i < lowest_q) begin
                lowest_d   = rd_usage_i;
                best_d     = cur;
                have_low_d = 1'b1;
              end
              idx_d = idx_q + 1'b1;
            end
          end

          scp_pkg::OP_CLEAR: begin
            if (scan_end) begin
              res_kind_d = scp_pkg::KIND_NOT_FOUND;
              res_slot_d = '0;
              state_d    = S_DONE;
            end else if (tag_hit) begin
              res_kind_d = scp_pkg::KIND_CLEARED;
              res_slot_d = scp_pkg::SlotOutBits'(cur);
              state_d    = (wb_en_i && rd_dirty_i) ? S_WB : S_DONE;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end

          scp_pkg::OP_FLUSH: begin
            if (scan_end) begin
              res_kind_d = scp_pkg::KIND_DEV_FLUSH;
              res_slot_d = '0;
              state_d    = S_DONE;
            end else if (rd_dirty_i) begin
              // hold the scan until the output register frees up
              if (out_free) begin
                out_valid_d = 1'b1;
                kind_d      = scp_pkg::KIND_WRITEBACK;
                slot_d      = scp_pkg::SlotOutBits'(cur);
                block_d     = rd_tag_i;
                last_d      = 1'b0;
                wr_o.dirty_en = 1'b1;
                idx_d       = idx_q + 1'b1;
              end
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end

          scp_pkg::OP_RECORD: begin
            res_slot_d = sidx_q;
            if ({1'b0, sidx_q} < 4'(SLOTS)) begin
              res_kind_d    = scp_pkg::KIND_RECORDED;
              wr_idx_o      = sidx_q[SlotW-1:0];
              wr_o.tag_en   = 1'b1;
              wr_o.dirty_en = 1'b1;
              wr_o.usage_en = 1'b1;
              wr_o.tag      = blk_q;
              wr_o.dirty    = din_q;
              wr_o.usage    = uin_q;
            end else begin
              res_kind_d = scp_pkg::KIND_NOT_FOUND;
            end
            state_d = S_DONE;
          end

          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_WB: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = scp_pkg::KIND_WRITEBACK;
          slot_d      = scp_pkg::SlotOutBits'(cur);
          block_d     = rd_tag_i;
          last_d      = 1'b0;
          state_d     = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = res_kind_q;
          slot_d      = res_slot_q;
          block_d     = '0;
          last_d      = 1'b1;
          // drop the cleared slot: tag, dirty bit and usage all to zero
          if (op_q == scp_pkg::OP_CLEAR && res_kind_q == scp_pkg::KIND_CLEARED) begin
            wr_o.tag_en   = 1'b1;
            wr_o.dirty_en = 1'b1;
            wr_o.usage_en = 1'b1;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rr_q         <= '0;
      out_valid_q  <= 1'b0;
      op_q         <= scp_pkg::OP_SELECT;
      blk_q        <= '0;
      sidx_q       <= '0;
      din_q        <= 1'b0;
      uin_q        <= '0;
      idx_q        <= '0;
      clean_q      <= '0;
      have_clean_q <= 1'b0;
      best_q       <= '0;
      have_low_q   <= 1'b0;
      lowest_q     <= scp_pkg::UsageMax;
      res_kind_q   <= scp_pkg::KIND_SELECTED;
      res_slot_q   <= '0;
      kind_q       <= scp_pkg::KIND_SELECTED;
      slot_q       <= '0;
      block_q      <= '0;
      last_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      rr_q         <= rr_d;
      out_valid_q  <= out_valid_d;
      op_q         <= op_d;
      blk_q        <= blk_d;
      sidx_q       <= sidx_d;
      din_q        <= din_d;
      uin_q        <= uin_d;
      idx_q        <= idx_d;
      clean_q      <= clean_d;
      have_clean_q <= have_clean_d;
      best_q       <= best_d;
      have_low_q   <= have_low_d;
      lowest_q     <= lowest_d;
      res_kind_q   <= res_kind_d;
      res_slot_q   <= res_slot_d;
      kind_q       <= kind_d;
      slot_q       <= slot_d;
      block_q      <= block_d;
      last_q       <= last_d;
    end
  end

endmodule

// File: hw/rtl/sector_cache_slot_policy.sv
// Operation: a select, clear or flush walks the slots in order, one slot per cycle,
// through one shared tag and usage comparator; a flush holds on a dirty slot until the
// output register frees up. A select stops at a dirty slot holding its block, a clear
// at its tag hit; a record visits no slot. Requests are taken one at a time; each stalls
// while the consumer holds a result off. Reset: asynchronous, active low; all tags, dirty
// bits, usage counts and the round-robin pointer go to zero, writeback_enable to one.
module sector_cache_slot_policy #(
  // Valid range 2 to 8: slot numbers travel on three-bit fields
  parameter int unsigned SLOTS = scp_pkg::DefSlots
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        opcode_i,
  input  logic [scp_pkg::TagBits-1:0]       block_number_i,
  input  logic [2:0]                        slot_index_i,
  input  logic                              dirty_in_i,
  input  logic [scp_pkg::UsageBits-1:0]     usage_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2:0]                        kind_o,
  output logic [2:0]                        slot_out_o,
  output logic [scp_pkg::TagBits-1:0]       block_out_o,
  output logic                              last_o
);

  localparam int unsigned SlotW = $clog2(SLOTS);

  // Write-back enable for clear requests; resets to enabled
  logic wb_en_q;

  logic [SlotW-1:0]              rd_idx;
  logic [scp_pkg::TagBits-1:0]   rd_tag;
  logic                          rd_dirty;
  logic [scp_pkg::UsageBits-1:0] rd_usage;
  logic [SlotW-1:0]              wr_idx;
  scp_pkg::wr_cmd_t              wr_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      wb_en_q <= cfg_wdata_i;
    end
  end

  // Per-slot tag, dirty bit and usage count; one read and one write port
  scp_store #(
    .SLOTS (SLOTS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (rd_idx),
    .rd_tag_o   (rd_tag),
    .rd_dirty_o (rd_dirty),
    .rd_usage_o (rd_usage),
    .wr_idx_i   (wr_idx),
    .wr_i       (wr_cmd)
  );

  // Sequencer: walks the slots with the shared comparator, owns the result register
  scp_seq #(
    .SLOTS (SLOTS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wb_en_i        (wb_en_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .block_number_i (block_number_i),
    .slot_index_i   (slot_index_i),
    .dirty_in_i     (dirty_in_i),
    .usage_in_i     (usage_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .slot_out_o     (slot_out_o),
    .block_out_o    (block_out_o),
    .last_o         (last_o),
    .rd_idx_o       (rd_idx),
    .rd_tag_i       (rd_tag),
    .rd_dirty_i     (rd_dirty),
    .rd_usage_i     (rd_usage),
    .wr_idx_o       (wr_idx),
    .wr_o           (wr_cmd)
  );

endmodule
